// ===== rtl/ccacc_pkg.sv =====
// shared types and codes for the cross-correlation accumulator
// used by the top level, the checker and the testbench, no dependencies
`timescale 1ns / 1ps

package ccacc_pkg;

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_RANGE = 2'd1,
		STS_ABOVE = 2'd2,
		STS_SAT   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUSH,
		ST_DRAIN,
		ST_READ,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic [4:0]         station;
		logic [4:0]         partner;
		logic signed [15:0] sample_re;
		logic signed [15:0] sample_im;
	} req_word_t;

	typedef struct packed {
		logic signed [47:0] acc_re;
		logic signed [47:0] acc_im;
		logic [1:0]         status;
	} rsp_word_t;

endpackage

// ===== rtl/ccacc_cell.sv =====
// one station slot of the rotating snapshot ring
// standalone, no package use
`timescale 1ns / 1ps

module ccacc_cell #(
	parameter int W = 32
) (
	input  logic         clk,
	input  logic         shift,
	input  logic [W-1:0] nbr,
	input  logic         wr_en,
	input  logic [W-1:0] wr_val,
	output logic [W-1:0] q
);

	logic [W-1:0] sample_q;

	// a fresh sample replaces the one passing through this slot
	always_ff @(posedge clk) begin
		if (shift) begin
			sample_q <= wr_en ? wr_val : nbr;
		end
	end

	assign q = sample_q;

endmodule

// ===== rtl/ccacc_mac.sv =====
// pipelined conjugate multiply and saturating accumulate, one entry a cycle
// no package use; accumulator memory lives in the top level
`timescale 1ns / 1ps

module ccacc_mac #(
	parameter int SW   = 16,
	parameter int AW   = 48,
	parameter int AD_W = 10
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step_valid,
	input  logic [AD_W-1:0] step_addr,
	input  logic [2*SW-1:0] x_smp,
	input  logic [2*SW-1:0] y_smp,
	input  logic            fresh,
	input  logic [2*AW-1:0] rd_data,
	output logic [AD_W-1:0] rd_addr,
	output logic            wr_en,
	output logic [AD_W-1:0] wr_addr,
	output logic [2*AW-1:0] wr_data,
	output logic            sat
);

	localparam int PW = 2 * SW;
	localparam int SUM_W = PW + 1;
	localparam int EW = ((AW > SUM_W) ? AW : SUM_W) + 1;

	logic signed [SW-1:0] xr, xi, yr, yi;
	logic signed [PW-1:0] p_rr_s1, p_ii_s1, p_ir_s1, p_ri_s1;
	logic                 valid_s1, valid_s2;
	logic [AD_W-1:0]      addr_s1, addr_s2;
	logic signed [SUM_W-1:0] sre_s2, sim_s2;
	logic signed [AW-1:0] acc_re, acc_im, new_re, new_im;
	logic                 sat_re, sat_im;

	assign xr = x_smp[2*SW-1:SW];
	assign xi = x_smp[SW-1:0];
	assign yr = y_smp[2*SW-1:SW];
	assign yi = y_smp[SW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= step_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		p_rr_s1 <= xr * yr;
		p_ii_s1 <= xi * yi;
		p_ir_s1 <= xi * yr;
		p_ri_s1 <= xr * yi;
		addr_s1 <= step_addr;
		addr_s2 <= addr_s1;
		sre_s2  <= SUM_W'(p_rr_s1) + SUM_W'(p_ii_s1);
		sim_s2  <= SUM_W'(p_ir_s1) - SUM_W'(p_ri_s1);
	end

	function automatic logic [AW:0] sat_add(logic signed [AW-1:0] a,
			logic signed [SUM_W-1:0] p);
		logic signed [EW-1:0] s, hi, lo;
		hi = {{(EW-AW+1){1'b0}}, {(AW-1){1'b1}}};
		lo = ~hi;
		s = EW'(a) + EW'(p);
		if (s > hi) begin
			return {1'b1, AW'(hi)};
		end else if (s < lo) begin
			return {1'b1, AW'(lo)};
		end
		return {1'b0, AW'(s)};
	endfunction

	// a row never touched since the last clear reads as zero
	assign acc_re = fresh ? '0 : rd_data[2*AW-1:AW];
	assign acc_im = fresh ? '0 : rd_data[AW-1:0];

	assign {sat_re, new_re} = sat_add(acc_re, sre_s2);
	assign {sat_im, new_im} = sat_add(acc_im, sim_s2);

	assign rd_addr = addr_s1;
	assign wr_en   = valid_s2;
	assign wr_addr = addr_s2;
	assign wr_data = {new_re, new_im};
	assign sat     = valid_s2 && (sat_re || sat_im);

endmodule

// ===== rtl/cross_correlation_accumulator.sv =====
// push: a full ring turn of the snapshot cells, one complex multiply-accumulate per cycle for
// partners 0 up to the station, then a drain of the multiply-accumulate pipeline, then the result word
// read: one accumulator memory read; clear, unused and rejected pushes go straight to the result
// one word in flight; the next is taken the cycle after the result is loaded, also while
// it waits at the output
// reset clears control and row-valid bits, sets num_stations to 32; snapshots undefined
`timescale 1ns / 1ps

module cross_correlation_accumulator #(
	parameter int MAX_STATIONS = 32,
	parameter int SAMPLE_BITS  = 16,
	parameter int ACC_BITS     = 48
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [5:0]           cfg_wdata,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  ccacc_pkg::req_word_t req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output ccacc_pkg::rsp_word_t rsp
);

	localparam int N    = MAX_STATIONS;
	localparam int SW   = SAMPLE_BITS;
	localparam int AW   = ACC_BITS;
	localparam int NE   = N * (N + 1) / 2;
	localparam int ST_W = $clog2(N);
	localparam int AD_W = $clog2(NE);

	ccacc_pkg::state_t  state_q, state_d;
	ccacc_pkg::op_t     op_in, op_q;
	ccacc_pkg::status_t status_q, status_in;
	ccacc_pkg::rsp_word_t rsp_q;

	logic [5:0]        num_st_q;
	logic [N-1:0]      row_valid_q;
	logic [ST_W-1:0]   x_q, cnt_q;
	logic [AD_W-1:0]   base_q, rd_addr_q, mem_addr;
	logic [2*SW-1:0]   new_q, head;
	logic [2*SW-1:0]   ring_q [N];
	logic [2*AW-1:0]   acc_mem [NE];
	logic [2*AW-1:0]   rd_q;
	logic              drain_q, sat_q, rsp_valid_q;
	logic              row_ok, col_ok, hit, step_valid, rsp_load, shift;
	logic [AD_W-1:0]   step_addr, mac_rd_addr, wr_addr;
	logic              wr_en, mac_sat;
	logic [2*AW-1:0]   wr_data;
	logic [AD_W-1:0]   base_in;
	logic [ST_W-1:0]   row_in;

	assign op_in  = ccacc_pkg::op_t'(req.operation);
	assign row_ok = ({1'b0, req.station} < num_st_q) && (32'(req.station) < N);
	assign col_ok = ({1'b0, req.partner} < num_st_q) && (32'(req.partner) < N);
	assign row_in = ST_W'(32'(req.station));
	assign base_in = AD_W'((32'(row_in) * (32'(row_in) + 32'd1)) >> 1);

	always_comb begin
		if (!row_ok || !col_ok) begin
			status_in = ccacc_pkg::STS_RANGE;
		end else if (req.partner > req.station) begin
			status_in = ccacc_pkg::STS_ABOVE;
		end else begin
			status_in = ccacc_pkg::STS_OK;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ccacc_pkg::ST_IDLE: begin
				if (req_valid) begin
					unique case (op_in)
						ccacc_pkg::OP_PUSH: state_d = row_ok ? ccacc_pkg::ST_PUSH
							: ccacc_pkg::ST_DONE;
						ccacc_pkg::OP_READ: state_d = ccacc_pkg::ST_READ;
						default: state_d = ccacc_pkg::ST_DONE;
					endcase
				end
			end
			ccacc_pkg::ST_PUSH: begin
				if (cnt_q == ST_W'(N - 1)) begin
					state_d = ccacc_pkg::ST_DRAIN;
				end
			end
			ccacc_pkg::ST_DRAIN: begin
				if (drain_q) begin
					state_d = ccacc_pkg::ST_DONE;
				end
			end
			ccacc_pkg::ST_READ: state_d = ccacc_pkg::ST_DONE;
			ccacc_pkg::ST_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					state_d = ccacc_pkg::ST_IDLE;
				end
			end
			default: state_d = ccacc_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		req_ready  = (state_q == ccacc_pkg::ST_IDLE);
		shift      = (state_q == ccacc_pkg::ST_PUSH);
		step_valid = (state_q == ccacc_pkg::ST_PUSH) && (cnt_q <= x_q);
		rsp_load   = (state_q == ccacc_pkg::ST_DONE) && (!rsp_valid_q || rsp_ready);
		// the read address holds while a read result waits for the output register
		mem_addr   = (state_q == ccacc_pkg::ST_PUSH || state_q == ccacc_pkg::ST_DRAIN)
			? mac_rd_addr : rd_addr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ccacc_pkg::ST_IDLE;
			num_st_q    <= 6'd32;
			row_valid_q <= '0;
			cnt_q       <= '0;
			drain_q     <= 1'b0;
			sat_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				num_st_q <= cfg_wdata;
			end
			if (req_valid && req_ready) begin
				cnt_q   <= '0;
				drain_q <= 1'b0;
				if (op_in == ccacc_pkg::OP_CLEAR) begin
					row_valid_q <= '0;
				end
			end else if (state_q == ccacc_pkg::ST_PUSH) begin
				cnt_q <= cnt_q + ST_W'(1);
			end else if (state_q == ccacc_pkg::ST_DRAIN) begin
				drain_q <= 1'b1;
				if (drain_q) begin
					row_valid_q[x_q] <= 1'b1;
				end
			end
			if (req_valid && req_ready) begin
				sat_q <= 1'b0;
			end else if (mac_sat) begin
				sat_q <= 1'b1;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			op_q      <= op_in;
			x_q       <= row_in;
			base_q    <= base_in;
			rd_addr_q <= base_in + AD_W'(32'(req.partner));
			new_q     <= {SW'($unsigned(req.sample_re)), SW'($unsigned(req.sample_im))};
			status_q  <= (op_in == ccacc_pkg::OP_PUSH)
				? (row_ok ? ccacc_pkg::STS_OK : ccacc_pkg::STS_RANGE)
				: ((op_in == ccacc_pkg::OP_READ) ? status_in : ccacc_pkg::STS_OK);
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			unique case (op_q)
				ccacc_pkg::OP_PUSH: begin
					rsp_q.acc_re <= '0;
					rsp_q.acc_im <= '0;
					rsp_q.status <= (status_q == ccacc_pkg::STS_OK && sat_q)
						? ccacc_pkg::STS_SAT : status_q;
				end
				ccacc_pkg::OP_READ: begin
					rsp_q.status <= status_q;
					if (status_q == ccacc_pkg::STS_OK && row_valid_q[x_q]) begin
						rsp_q.acc_re <= 48'(rd_q[2*AW-1:AW]);
						rsp_q.acc_im <= 48'(rd_q[AW-1:0]);
					end else begin
						rsp_q.acc_re <= '0;
						rsp_q.acc_im <= '0;
					end
				end
				default: begin
					rsp_q.acc_re <= '0;
					rsp_q.acc_im <= '0;
					rsp_q.status <= ccacc_pkg::STS_OK;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// snapshot ring: slot 0 is the head, the sample at the head wraps to the tail
	assign hit  = (cnt_q == x_q);
	assign head = hit ? new_q : ring_q[0];

	for (genvar k = 0; k < N; k++) begin : g_cell
		if (k == N - 1) begin : g_tail
			ccacc_cell #(.W(2 * SW)) u_cell (
				.clk    (clk),
				.shift  (shift),
				.nbr    (ring_q[0]),
				.wr_en  (hit),
				.wr_val (new_q),
				.q      (ring_q[k])
			);
		end else begin : g_body
			ccacc_cell #(.W(2 * SW)) u_cell (
				.clk    (clk),
				.shift  (shift),
				.nbr    (ring_q[k+1]),
				.wr_en  (1'b0),
				.wr_val (new_q),
				.q      (ring_q[k])
			);
		end
	end

	assign step_addr = base_q + AD_W'(cnt_q);

	ccacc_mac #(.SW(SW), .AW(AW), .AD_W(AD_W)) u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_valid (step_valid),
		.step_addr  (step_addr),
		.x_smp      (new_q),
		.y_smp      (head),
		.fresh      (!row_valid_q[x_q]),
		.rd_data    (rd_q),
		.rd_addr    (mac_rd_addr),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.sat        (mac_sat)
	);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			acc_mem[wr_addr] <= wr_data;
		end
		rd_q <= acc_mem[mem_addr];
	end

`ifndef SYNTH
	a_wr_in_push: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ccacc_pkg::ST_PUSH || state_q == ccacc_pkg::ST_DRAIN))
		else $error("accumulator written outside a push");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status != ccacc_pkg::STS_OK)
		|-> (rsp.acc_re == 0 && rsp.acc_im == 0))
		else $error("nonzero accumulator on a failed word");

	a_push_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ccacc_pkg::ST_PUSH) |=> !req_ready || $past(cnt_q) == ST_W'(N - 1))
		else $error("word accepted during a push");
`endif

endmodule

// ===== dv/ccacc_checker.sv =====
// result checker for the cross-correlation accumulator: watches both channels,
// keeps its own copy of snapshots, accumulators and station count; needs ccacc_pkg
`timescale 1ns / 1ps

module ccacc_checker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [5:0]           cfg_wdata,
	input  logic                 req_valid,
	input  logic                 req_ready,
	input  ccacc_pkg::req_word_t req,
	input  logic                 rsp_valid,
	input  logic                 rsp_ready,
	input  ccacc_pkg::rsp_word_t rsp,
	output int                   errors,
	output int                   pending
);

	localparam int NSTA = 32;
	localparam longint ACC_MAX = (64'sd1 <<< 47) - 1;
	localparam longint ACC_MIN = -ACC_MAX - 1;

	longint snap_re [NSTA];
	longint snap_im [NSTA];
	longint vis_re [NSTA*(NSTA+1)/2];
	longint vis_im [NSTA*(NSTA+1)/2];
	logic [5:0] stations_in_use;
	ccacc_pkg::rsp_word_t expected_words [$];

	assign pending = expected_words.size();

	function automatic longint sat_acc(longint a, longint p, inout bit hit);
		longint s;
		s = a + p;
		if (s > ACC_MAX) begin
			hit = 1;
			return ACC_MAX;
		end
		if (s < ACC_MIN) begin
			hit = 1;
			return ACC_MIN;
		end
		return s;
	endfunction

	function automatic bit in_range(int s);
		return s < stations_in_use && s < NSTA;
	endfunction

	// updates the model for one accepted word and returns the word it should produce
	function automatic ccacc_pkg::rsp_word_t correlate(ccacc_pkg::req_word_t w);
		ccacc_pkg::rsp_word_t r;
		int row, col, base, idx;
		longint xr, xi, yr, yi;
		bit hit;
		r = '0;
		row = int'(w.station);
		col = int'(w.partner);
		base = row * (row + 1) / 2;
		hit = 0;
		case (ccacc_pkg::op_t'(w.operation))
			ccacc_pkg::OP_PUSH: begin
				if (!in_range(row)) begin
					r.status = ccacc_pkg::STS_RANGE;
				end else begin
					xr = w.sample_re;
					xi = w.sample_im;
					snap_re[row] = xr;
					snap_im[row] = xi;
					for (int y = 0; y <= row; y++) begin
						yr = snap_re[y];
						yi = snap_im[y];
						idx = base + y;
						vis_re[idx] = sat_acc(vis_re[idx], xr * yr + xi * yi, hit);
						vis_im[idx] = sat_acc(vis_im[idx], xi * yr - xr * yi, hit);
					end
					if (hit)
						r.status = ccacc_pkg::STS_SAT;
				end
			end
			ccacc_pkg::OP_READ: begin
				if (!in_range(row) || !in_range(col)) begin
					r.status = ccacc_pkg::STS_RANGE;
				end else if (col > row) begin
					r.status = ccacc_pkg::STS_ABOVE;
				end else begin
					r.acc_re = vis_re[base + col][47:0];
					r.acc_im = vis_im[base + col][47:0];
				end
			end
			ccacc_pkg::OP_CLEAR: begin
				foreach (vis_re[i]) begin
					vis_re[i] = 0;
					vis_im[i] = 0;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ccacc_pkg::rsp_word_t e;
		if (!arst_n) begin
			foreach (vis_re[i]) begin
				vis_re[i] = 0;
				vis_im[i] = 0;
			end
			foreach (snap_re[i]) begin
				snap_re[i] = 0;
				snap_im[i] = 0;
			end
			stations_in_use = 6'd32;
			expected_words.delete();
			errors = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_words.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%t unexpected result word %h", $realtime, rsp);
				end else begin
					e = expected_words.pop_front();
					if (rsp.acc_re !== e.acc_re || rsp.acc_im !== e.acc_im
							|| rsp.status !== e.status) begin
						errors++;
						if (errors <= 10)
							$display({"%t mismatch: expected re %0d im %0d status %0d,",
								" got re %0d im %0d status %0d"},
								$realtime, e.acc_re, e.acc_im, e.status,
								rsp.acc_re, rsp.acc_im, rsp.status);
					end
				end
			end
			if (req_valid && req_ready)
				expected_words.push_back(correlate(req));
			if (cfg_we)
				stations_in_use = cfg_wdata;
		end
	end

endmodule

// ===== dv/cross_correlation_accumulator_tb.sv =====
// top of the cross-correlation accumulator testbench: clock, reset, stimulus, verdict
// depends on ccacc_pkg, cross_correlation_accumulator and ccacc_checker
`timescale 1ns / 1ps

module cross_correlation_accumulator_tb;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [5:0] cfg_wdata = '0;
	logic req_valid = 0;
	logic req_ready;
	ccacc_pkg::req_word_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 0;
	ccacc_pkg::rsp_word_t rsp;
	int errors, pending;

	int send_idle = 0;
	int recv_idle = 0;
	logic hold = 0;
	int n_eff = 32;
	int written_prefix = 0;   // stations 0..prefix-1 hold a snapshot
	int words_sent = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	cross_correlation_accumulator dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	ccacc_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.errors(errors), .pending(pending)
	);

	always @(posedge clk)
		rsp_ready <= !hold && ($urandom_range(99) >= recv_idle);

	initial begin
		#5_000_000;
		$display("cross_correlation_accumulator_tb: done, errors");
		$finish;
	end

	task automatic offer(ccacc_pkg::req_word_t w);
		if ($urandom_range(99) < send_idle) begin
			req_valid <= 0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		req_valid <= 1;
		req <= w;
		do @(posedge clk); while (!req_ready);
		words_sent++;
	endtask

	task automatic set_stations(int v);
		req_valid <= 0;
		wait (pending == 0);
		repeat (40) @(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= 6'(v);
		@(posedge clk);
		cfg_we <= 0;
		n_eff = (v > 32) ? 32 : v;
	endtask

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	// never lets a push read a snapshot that was not written yet
	task automatic push(int st, logic [15:0] re, logic [15:0] im);
		ccacc_pkg::req_word_t w;
		if (st < n_eff && st > written_prefix)
			st = written_prefix;
		if (st < n_eff && st == written_prefix)
			written_prefix++;
		w = '0;
		w.operation = ccacc_pkg::OP_PUSH;
		w.station = 5'(st);
		w.sample_re = re;
		w.sample_im = im;
		offer(w);
	endtask

	task automatic command(ccacc_pkg::op_t op, int row, int col);
		ccacc_pkg::req_word_t w;
		w = '0;
		w.operation = op;
		w.station = 5'(row);
		w.partner = 5'(col);
		w.sample_re = 16'($urandom);
		w.sample_im = 16'($urandom);
		offer(w);
	endtask

	task automatic random_words(int count);
		int r, row;
		while (count > 0) begin
			r = $urandom_range(99);
			if (r < 60) begin
				for (int s = 0; s < n_eff && count > 0; s++) begin
					if (s < written_prefix && $urandom_range(19) == 0)
						continue;
					push(s, pick_sample(), pick_sample());
					count--;
				end
			end else begin
				if (r < 85) begin
					if ($urandom_range(3) == 0) begin
						command(ccacc_pkg::OP_READ, $urandom_range(31), $urandom_range(31));
					end else begin
						row = $urandom_range(n_eff > 0 ? n_eff - 1 : 0);
						command(ccacc_pkg::OP_READ, row, $urandom_range(row));
					end
				end else if (r < 88) begin
					command(ccacc_pkg::OP_CLEAR, $urandom_range(31), $urandom_range(31));
				end else if (r < 92) begin
					command(ccacc_pkg::OP_NONE, $urandom_range(31), $urandom_range(31));
				end else begin
					push($urandom_range(31), pick_sample(), pick_sample());
				end
				count--;
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// extremes, every operation, statuses ok, range and above
		push(0, 16'h8000, 16'h8000);
		push(1, 16'h7fff, 16'h7fff);
		push(2, 16'h8000, 16'h7fff);
		push(3, 16'h7fff, 16'h8000);
		command(ccacc_pkg::OP_READ, 1, 0);
		command(ccacc_pkg::OP_READ, 0, 0);
		command(ccacc_pkg::OP_READ, 3, 2);
		command(ccacc_pkg::OP_READ, 0, 1);
		command(ccacc_pkg::OP_READ, 31, 31);
		push(1, 16'hffff, 16'h0001);
		command(ccacc_pkg::OP_READ, 1, 1);
		command(ccacc_pkg::OP_CLEAR, 0, 0);
		command(ccacc_pkg::OP_READ, 1, 0);
		command(ccacc_pkg::OP_NONE, 31, 31);
		set_stations(1);
		push(0, 16'h1234, 16'hedcb);
		push(1, 16'h1111, 16'h2222);
		command(ccacc_pkg::OP_READ, 1, 0);
		command(ccacc_pkg::OP_READ, 0, 0);
		set_stations(0);
		push(0, 16'h7fff, 16'h7fff);
		command(ccacc_pkg::OP_READ, 0, 0);
		set_stations(63);
		push(4, 16'h0f0f, 16'hf0f0);
		command(ccacc_pkg::OP_READ, 31, 0);

		set_stations($urandom_range(32, 2));
		send_idle = 13;
		recv_idle = 51;
		// long receiver hold-off while words keep coming
		fork
			begin
				@(posedge clk);
				hold <= 1;
				repeat (400) @(posedge clk);
				hold <= 0;
			end
		join_none
		random_words(300);
		req_valid <= 0;
		wait (pending == 0);
		random_words(300);

		set_stations(32);
		send_idle = 51;
		recv_idle = 13;
		random_words(600);

		set_stations($urandom_range(1) ? 63 : $urandom_range(32, 1));
		send_idle = 0;
		recv_idle = 0;
		random_words(600);
		req_valid <= 0;

		wait (pending == 0);
		repeat (60) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("cross_correlation_accumulator_tb: done, clean");
		else
			$display("cross_correlation_accumulator_tb: done, errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/ccacc_pkg.sv
rtl/ccacc_cell.sv
rtl/ccacc_mac.sv
rtl/cross_correlation_accumulator.sv
dv/ccacc_checker.sv
dv/cross_correlation_accumulator_tb.sv
